FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define SFRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// Clocked assertion that also holds during reset.
`define SFRC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("%m: assertion failed");

`endif

FILE: rtl/sfrc_pkg.sv
// Shared types and constants for the serial frame receiver with checksum.
// No dependencies.
`timescale 1ns / 1ps

package sfrc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned StatW  = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // Frame position of the first payload byte.
  localparam logic [WordW-1:0] DataStart = 16'd8;

  localparam logic [ByteW-1:0] HeaderFirstRst  = 8'h00;
  localparam logic [ByteW-1:0] HeaderSecondRst = 8'h00;
  localparam logic [ByteW-1:0] OwnIdRst        = 8'h01;
  localparam logic [WordW-1:0] MaxLengthRst    = 16'd256;

  typedef enum logic [3:0] {
    PhHdr1  = 4'd0,
    PhHdr2  = 4'd1,
    PhFrame = 4'd2,
    PhId    = 4'd3,
    PhCmd   = 4'd4,
    PhLenHi = 4'd5,
    PhLenLo = 4'd6,
    PhRsvd  = 4'd7,
    PhData  = 4'd8,
    PhSumHi = 4'd9,
    PhSumLo = 4'd10
  } phase_e;

  typedef enum logic [StatW-1:0] {
    StHunt       = 3'd0,
    StInFrame    = 3'd1,
    StGood       = 3'd2,
    StBadSum     = 3'd3,
    StIdMismatch = 3'd4,
    StLenReject  = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHeaderFirst  = 3'd0,
    CfgHeaderSecond = 3'd1,
    CfgOwnId        = 3'd2,
    CfgMaxLength    = 3'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] header_first;
    logic [ByteW-1:0] header_second;
    logic [ByteW-1:0] own_id;
    logic [WordW-1:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [WordW-1:0] position;
    status_e          status;
  } res_t;

endpackage

FILE: rtl/sfrc_if.sv
// Valid/ready channel interfaces: received bytes, results, config writes.
// Depends on sfrc_pkg.
`timescale 1ns / 1ps

interface sfrc_rx_if import sfrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfrc_res_if import sfrc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic [WordW-1:0] position;
  logic [StatW-1:0] status;

  modport source (output valid, output data_byte, output position, output status,
                  input ready);
  modport sink   (input valid, input data_byte, input position, input status,
                  output ready);
endinterface

interface sfrc_cfg_if import sfrc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/serial_frame_receiver_checksum_unit.sv
// Top level of the serial frame receiver with 16-bit additive checksum.
// Depends on sfrc_pkg, sfrc_if, sfrc_cfg_regs and sfrc_parser.
`timescale 1ns / 1ps

// Takes one received byte per word on rx_i and returns one result word per
// byte on res_o: the byte echoed, its position in the current frame and a
// status (hunting, in frame, frame good, checksum bad, ID mismatch, length
// rejected). Frame: two header bytes, frame number, module ID, command,
// 16-bit big-endian length, reserved byte, payload, 16-bit sum high byte
// first; the sum covers length through payload. Rate is one byte per
// clock while res_o does not stall: a byte sits in the input register,
// and the parser updates its state and the result register in the cycle
// it moves on; res_o.valid is driven from the result register. The result
// register frees rx_i while res_o stalls until the input register also
// holds a byte.
// Configuration writes on cfg_i are always ready; write them only with
// both registers empty.

module serial_frame_receiver_checksum_unit import sfrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfrc_rx_if.sink     rx_i,
  sfrc_res_if.source  res_o,
  sfrc_cfg_if.sink    cfg_i
);

  cfg_t cfg;
  res_t step_res;

  // input register
  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             rx_take;

  // result register
  logic out_valid_q, out_valid_d;
  res_t out_q;

  logic advance;  // byte in input register is parsed this cycle

  assign advance    = in_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !in_valid_q || advance;
  assign rx_take    = rx_i.valid && rx_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (rx_take)      in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance)          out_valid_d = 1'b1;
    else if (res_o.ready) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (rx_take) in_byte_q <= rx_i.rx_byte;
    if (advance) out_q     <= step_res;
  end

  sfrc_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  sfrc_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .res_o  (step_res)
  );

  assign res_o.valid     = out_valid_q;
  assign res_o.data_byte = out_q.data_byte;
  assign res_o.position  = out_q.position;
  assign res_o.status    = out_q.status;

endmodule

FILE: rtl/sfrc_cfg_regs.sv
// Configuration register file: header bytes, module ID, length limit.
// Depends on sfrc_pkg and sfrc_cfg_if.
`timescale 1ns / 1ps

module sfrc_cfg_regs import sfrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfrc_cfg_if.sink    cfg_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CfgHeaderFirst:  cfg_d.header_first  = cfg_i.data[ByteW-1:0];
        CfgHeaderSecond: cfg_d.header_second = cfg_i.data[ByteW-1:0];
        CfgOwnId:        cfg_d.own_id        = cfg_i.data[ByteW-1:0];
        CfgMaxLength:    cfg_d.max_length    = cfg_i.data[WordW-1:0];
        default:         cfg_d = cfg_q;  // writes beyond the map are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first  <= HeaderFirstRst;
      cfg_q.header_second <= HeaderSecondRst;
      cfg_q.own_id        <= OwnIdRst;
      cfg_q.max_length    <= MaxLengthRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/sfrc_parser.sv
// Frame parser: phase FSM, byte counter, length and running sum.
// Depends on sfrc_pkg.
`timescale 1ns / 1ps

module sfrc_parser import sfrc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  input  cfg_t             cfg_i,
  output res_t             res_o
);

  phase_e           phase_q, phase_d;
  logic [WordW-1:0] count_q, count_d;
  logic [WordW-1:0] len_q, len_d;
  logic [WordW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] sum_hi_q, sum_hi_d;

  logic [WordW-1:0] pos;
  status_e          status;
  logic [WordW-1:0] len_full;
  logic [WordW-1:0] sum_add;
  logic             len_ok;
  logic             data_last;

  assign len_full  = {len_q[WordW-1:ByteW], byte_i};
  assign len_ok    = len_full < cfg_i.max_length;
  assign sum_add   = sum_q + {{(WordW-ByteW){1'b0}}, byte_i};
  assign data_last = (count_q - DataStart) == (len_q - 16'd1);

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PhHdr2: begin
        if (byte_i == cfg_i.header_second)     phase_d = PhFrame;
        else if (byte_i == cfg_i.header_first) phase_d = PhHdr2;
        else                                   phase_d = PhHdr1;
      end
      PhFrame: phase_d = PhId;
      PhId:    phase_d = (byte_i == cfg_i.own_id) ? PhCmd : PhHdr1;
      PhCmd:   phase_d = PhLenHi;
      PhLenHi: phase_d = PhLenLo;
      PhLenLo: phase_d = len_ok ? PhRsvd : PhHdr1;
      PhRsvd:  phase_d = (len_q == '0) ? PhSumHi : PhData;
      PhData:  phase_d = data_last ? PhSumHi : PhData;
      PhSumHi: phase_d = PhSumLo;
      PhSumLo: phase_d = PhHdr1;
      default: phase_d = (byte_i == cfg_i.header_first) ? PhHdr2 : PhHdr1;
    endcase
  end

  // per-byte outputs and datapath updates
  always_comb begin
    pos      = count_q;
    status   = StInFrame;
    len_d    = len_q;
    sum_d    = sum_q;
    sum_hi_d = sum_hi_q;
    unique case (phase_q)
      PhHdr2: begin
        if (byte_i == cfg_i.header_second) begin
          pos = count_q;
        end else if (byte_i == cfg_i.header_first) begin
          pos = '0;  // repeated first header byte restarts the frame
        end else begin
          status = StHunt;
        end
      end
      PhFrame, PhCmd: pos = count_q;
      PhId: begin
        if (byte_i != cfg_i.own_id) status = StIdMismatch;
      end
      PhLenHi: begin
        len_d = {byte_i, {ByteW{1'b0}}};
        sum_d = {{(WordW-ByteW){1'b0}}, byte_i};
      end
      PhLenLo: begin
        len_d = len_full;
        sum_d = sum_add;
        if (!len_ok) status = StLenReject;
      end
      PhRsvd, PhData: sum_d = sum_add;
      PhSumHi: sum_hi_d = byte_i;
      PhSumLo: status = (sum_q == {sum_hi_q, byte_i}) ? StGood : StBadSum;
      default: begin
        pos = '0;
        if (byte_i != cfg_i.header_first) status = StHunt;
      end
    endcase
    count_d = pos + 16'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHdr1;
      count_q  <= '0;
      len_q    <= '0;
      sum_q    <= '0;
      sum_hi_q <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      len_q    <= len_d;
      sum_q    <= sum_d;
      sum_hi_q <= sum_hi_d;
    end
  end

  assign res_o.data_byte = byte_i;
  assign res_o.position  = pos;
  assign res_o.status    = status;

endmodule

FILE: rtl/sfrc_checker.sv
// Port-level checks on the frame receiver's result channel, bound to the top.
// Depends on sfrc_pkg, assert_macros.svh and serial_frame_receiver_checksum_unit.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sfrc_checker import sfrc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input logic [ByteW-1:0] res_data_i,
  input logic [WordW-1:0] res_pos_i,
  input logic [StatW-1:0] res_status_i
);

  // stalled word stays offered and unchanged
  `SFRC_ASSERT(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i)
  `SFRC_ASSERT(a_res_stable, res_valid_i && !res_ready_i |=> $stable({res_data_i, res_pos_i, res_status_i}))

  // ID byte sits at position 3, low length byte at position 6
  `SFRC_ASSERT(a_id_pos, res_valid_i && res_status_i == StIdMismatch |-> res_pos_i == 16'd3)
  `SFRC_ASSERT(a_len_pos, res_valid_i && res_status_i == StLenReject |-> res_pos_i == 16'd6)

endmodule

bind serial_frame_receiver_checksum_unit sfrc_checker u_sfrc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_data_i   (res_o.data_byte),
  .res_pos_i    (res_o.position),
  .res_status_i (res_o.status)
);
